FILE: hdl/lidar_polar_to_cartesian_assert.svh
// Assertion macros used by the lidar polar-to-Cartesian top level.
`ifndef LIDAR_POLAR_TO_CARTESIAN_ASSERT_SVH
`define LIDAR_POLAR_TO_CARTESIAN_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define LPC_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("lidar_polar_to_cartesian: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define LPC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("lidar_polar_to_cartesian: next-cycle check failed");

`endif

FILE: hdl/lpc_pkg.sv
// Shared types, constants and sine table functions for the polar-to-Cartesian block.
package lpc_pkg;

	localparam int ANGLE_W     = 16;
	localparam int RANGE_W     = 16;
	localparam int COORD_W     = 17;
	localparam int ENTRY_W     = 17;
	localparam int PROD_W      = 32;
	localparam int CFG_INDEX_W = 8;
	localparam int CFG_DATA_W  = 16;
	localparam int FRAC_BITS   = 15;

	localparam int SINE_TABLE_BITS_DEF = 10;

	localparam longint unsigned PI_Q30 = 64'd3373259426;

	// Register indexes on the config port
	localparam logic [CFG_INDEX_W-1:0] REG_START_ANGLE = 8'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_ANGLE_STEP  = 8'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_RANGE_LOW   = 8'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_RANGE_HIGH  = 8'd3;

	typedef struct packed {
		logic [ANGLE_W-1:0] start_angle;
		logic [ANGLE_W-1:0] angle_step;
		logic [RANGE_W-1:0] range_low;
		logic [RANGE_W-1:0] range_high;
	} cfg_t;

	// sin of j/2^tbits turns, 0 <= j <= quarter turn, Q15, odd Taylor series in Q30
	function automatic int quarter_sine(int unsigned j, int unsigned tbits);
		longint unsigned x;
		longint unsigned term;
		longint          sum;
		longint          q;
		int unsigned     k;
		x = (longint'(j) * 64'd2 * PI_Q30 + (64'd1 << (tbits - 1))) >> tbits;
		term = x;
		sum = longint'(x);
		for (k = 1; k <= 7; k++) begin
			term = (term * x + (64'd1 << 29)) >> 30;
			term = (term * x + (64'd1 << 29)) >> 30;
			// Series denominator (2k)(2k+1)
			case (k)
				1: term = term / 64'd6;
				2: term = term / 64'd20;
				3: term = term / 64'd42;
				4: term = term / 64'd72;
				5: term = term / 64'd110;
				6: term = term / 64'd156;
				default: term = term / 64'd210;
			endcase
			if (k[0])
				sum = sum - longint'(term);
			else
				sum = sum + longint'(term);
		end
		if (sum < 0)
			sum = 0;
		q = (sum + 64'sd16384) >>> 15;
		if (q > 32768)
			q = 32768;
		return int'(q);
	endfunction

	// Full-turn sine table entry, built from the quarter wave by symmetry
	function automatic logic signed [ENTRY_W-1:0] sine_entry(int unsigned i, int unsigned tbits);
		int unsigned quarter;
		int unsigned quad;
		int unsigned j;
		int          v;
		quarter = (1 << tbits) >> 2;
		quad = (i >> (tbits - 2)) & 3;
		j = i & (quarter - 1);
		case (quad)
			0: v = quarter_sine(j, tbits);
			1: v = quarter_sine(quarter - j, tbits);
			2: v = -quarter_sine(j, tbits);
			default: v = -quarter_sine(quarter - j, tbits);
		endcase
		return ENTRY_W'(v);
	endfunction

endpackage

FILE: hdl/lpc_cfg_regs.sv
// Configuration register file: start angle, angle step and range window.
module lpc_cfg_regs import lpc_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   wr_en,
	input  logic [CFG_INDEX_W-1:0] wr_index,
	input  logic [CFG_DATA_W-1:0]  wr_data,
	output cfg_t                   cfg
);

	cfg_t cfg_q;

	// Writes to unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_angle <= '0;
			cfg_q.angle_step  <= '0;
			cfg_q.range_low   <= '0;
			cfg_q.range_high  <= '1;
		end else if (wr_en) begin
			case (wr_index)
				REG_START_ANGLE: cfg_q.start_angle <= wr_data;
				REG_ANGLE_STEP:  cfg_q.angle_step  <= wr_data;
				REG_RANGE_LOW:   cfg_q.range_low   <= wr_data;
				REG_RANGE_HIGH:  cfg_q.range_high  <= wr_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

FILE: hdl/lpc_front.sv
// Beam angle accumulator, table index and range window check.
module lpc_front import lpc_pkg::*; #(
	parameter int SINE_TABLE_BITS = SINE_TABLE_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  cfg_t                       cfg,
	input  logic                       fire,
	input  logic [RANGE_W-1:0]         range_mm,
	input  logic                       scan_start,
	output logic [SINE_TABLE_BITS-1:0] idx,
	output logic                       hit
);

	logic [ANGLE_W-1:0] beam_q;
	logic [ANGLE_W-1:0] angle_cur;

	// Scan start reloads the angle before it is used
	assign angle_cur = scan_start ? cfg.start_angle : beam_q;
	assign idx       = angle_cur[ANGLE_W-1 -: SINE_TABLE_BITS];
	assign hit       = (range_mm >= cfg.range_low) && (range_mm <= cfg.range_high);

	// Angle advances after every accepted item, in or out of the window
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			beam_q <= '0;
		end else if (fire) begin
			beam_q <= angle_cur + cfg.angle_step;
		end
	end

endmodule

FILE: hdl/lpc_sine_rom.sv
// Sine table ROM with two registered read ports (sine and cosine).
module lpc_sine_rom import lpc_pkg::*; #(
	parameter int SINE_TABLE_BITS = SINE_TABLE_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       en,
	input  logic [SINE_TABLE_BITS-1:0] idx,
	output logic signed [ENTRY_W-1:0]  sin_s1,
	output logic signed [ENTRY_W-1:0]  cos_s1
);

	localparam int TBL_SIZE    = 1 << SINE_TABLE_BITS;
	localparam int TBL_QUARTER = TBL_SIZE / 4;

	logic signed [ENTRY_W-1:0]  rom [TBL_SIZE];
	logic [SINE_TABLE_BITS-1:0] cos_idx;

	// Table contents are worked out at elaboration
	for (genvar gi = 0; gi < TBL_SIZE; gi++) begin : g_rom
		localparam logic signed [ENTRY_W-1:0] ENTRY = sine_entry(gi, SINE_TABLE_BITS);
		assign rom[gi] = ENTRY;
	end

	// cos is sin a quarter turn ahead
	assign cos_idx = idx + SINE_TABLE_BITS'(TBL_QUARTER);

	always_ff @(posedge clk) begin
		if (en) begin
			sin_s1 <= rom[idx];
			cos_s1 <= rom[cos_idx];
		end
	end

endmodule

FILE: hdl/lpc_scale.sv
// Range times table entry, rounded half away from zero to whole millimetres.
module lpc_scale import lpc_pkg::*; (
	input  logic                       clk,
	input  logic                       en_s2,
	input  logic                       en_out,
	input  logic [RANGE_W-1:0]         range_s1,
	input  logic signed [ENTRY_W-1:0]  entry_s1,
	output logic signed [COORD_W-1:0]  coord_q
);

	logic [RANGE_W-1:0]  mag;
	logic [ENTRY_W-1:0]  neg_entry;
	logic [PROD_W-1:0]   prod_s2;
	logic                neg_s2;
	logic [PROD_W-1:0]   rounded;
	logic [COORD_W-1:0]  p;

	// Magnitude of the entry; +1.0 (32768) still fits in 16 bits
	assign neg_entry = -entry_s1;
	assign mag       = entry_s1[ENTRY_W-1] ? neg_entry[RANGE_W-1:0] : entry_s1[RANGE_W-1:0];

	always_ff @(posedge clk) begin
		if (en_s2) begin
			prod_s2 <= range_s1 * mag;
			neg_s2  <= entry_s1[ENTRY_W-1];
		end
	end

	// Round the magnitude, then restore the sign
	assign rounded = (prod_s2 + (PROD_W'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
	assign p       = rounded[COORD_W-1:0];

	always_ff @(posedge clk) begin
		if (en_out) begin
			coord_q <= neg_s2 ? -p : p;
		end
	end

endmodule

FILE: hdl/lidar_polar_to_cartesian.sv
// Top level: lidar range samples to Cartesian points.
//
// Input stream (s_*): one range sample per item, range in tdata[15:0],
// scan-start flag in tuser. Output stream (m_*): one point per sample whose
// range lies in [range_low, range_high]; x in tdata[16:0], y in tdata[33:17].
// Samples outside the window give no point but still advance the beam angle.
// Config port (cfg_*): index 0 start angle, 1 angle step, 2 range low,
// 3 range high; cfg_ready is always high, other indexes are ignored.
// Write config only while no items are in flight.
// Throughput: one item per cycle while the receiver takes points. A point
// passes from the edge that accepts its sample through the ROM read register,
// multiplier register and output register; the last one drives m_tvalid.
// Reset clears the beam angle and the pipeline valids and loads register
// defaults (window 0..65535, angle and step zero).
// When the receiver stalls, the output register holds its point and the
// stages behind it keep filling; s_tready drops only once all three are full.
`include "lidar_polar_to_cartesian_assert.svh"
module lidar_polar_to_cartesian import lpc_pkg::*; #(
	parameter int SINE_TABLE_BITS = SINE_TABLE_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	// input item
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [15:0]            s_tdata,    // [15:0] range_mm
	input  logic                   s_tuser,    // [0] scan_start
	// result item
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [39:0]            m_tdata,    // [16:0] x_mm, [33:17] y_mm, rest zero
	// config writes
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	cfg_t                       cfg;
	logic                       s_fire;
	logic [SINE_TABLE_BITS-1:0] idx;
	logic                       hit;
	logic                       rdy1;
	logic                       rdy2;
	logic                       rdy3;
	logic                       valid_s1;
	logic                       valid_s2;
	logic                       out_valid_q;
	logic [RANGE_W-1:0]         range_s1;
	logic signed [ENTRY_W-1:0]  sin_s1;
	logic signed [ENTRY_W-1:0]  cos_s1;
	logic signed [COORD_W-1:0]  x_q;
	logic signed [COORD_W-1:0]  y_q;

	assign cfg_ready = 1'b1;

	lpc_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	// Each stage moves when it is empty or the next one moves
	assign rdy3     = !out_valid_q || m_tready;
	assign rdy2     = !valid_s2 || rdy3;
	assign rdy1     = !valid_s1 || rdy2;
	assign s_tready = rdy1;
	assign s_fire   = s_tvalid && s_tready;

	lpc_front #(
		.SINE_TABLE_BITS (SINE_TABLE_BITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.fire       (s_fire),
		.range_mm   (s_tdata),
		.scan_start (s_tuser),
		.idx        (idx),
		.hit        (hit)
	);

	lpc_sine_rom #(
		.SINE_TABLE_BITS (SINE_TABLE_BITS)
	) u_rom (
		.clk    (clk),
		.en     (rdy1),
		.idx    (idx),
		.sin_s1 (sin_s1),
		.cos_s1 (cos_s1)
	);

	// Stage 1: table read and sample range
	always_ff @(posedge clk) begin
		if (rdy1) begin
			range_s1 <= s_tdata;
		end
	end

	// Valid chain; rejected samples leave a bubble
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (rdy1)
				valid_s1 <= s_fire && hit;
			if (rdy2)
				valid_s2 <= valid_s1;
			if (rdy3)
				out_valid_q <= valid_s2;
		end
	end

	lpc_scale u_scale_x (
		.clk      (clk),
		.en_s2    (rdy2),
		.en_out   (rdy3),
		.range_s1 (range_s1),
		.entry_s1 (cos_s1),
		.coord_q  (x_q)
	);

	lpc_scale u_scale_y (
		.clk      (clk),
		.en_s2    (rdy2),
		.en_out   (rdy3),
		.range_s1 (range_s1),
		.entry_s1 (sin_s1),
		.coord_q  (y_q)
	);

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {6'b0, y_q, x_q};

	// Checks on the stage control
	`LPC_ASSERT_SAME(a_full_on_stall, clk, arst_n, !s_tready, m_tvalid && !m_tready && valid_s1 && valid_s2)
	`LPC_ASSERT_NEXT(a_reject_bubble, clk, arst_n, s_fire && !hit, !valid_s1)
	`LPC_ASSERT_NEXT(a_s2_to_out, clk, arst_n, valid_s2 && rdy3, m_tvalid)
	`LPC_ASSERT_NEXT(a_s1_holds, clk, arst_n, valid_s1 && !rdy2, valid_s1 && $stable(range_s1))

endmodule

FILE: dv/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for the lidar polar-to-Cartesian converter.
module tb_top;
	import lpc_pkg::*;

	localparam int LUT_BITS = SINE_TABLE_BITS_DEF;
	localparam int LUT_SIZE = 1 << LUT_BITS;
	localparam int LUT_QTR  = LUT_SIZE / 4;

	// Indexes that map to no register
	localparam logic [CFG_INDEX_W-1:0] REG_UNMAPPED_FIRST = 8'd4;
	localparam logic [CFG_INDEX_W-1:0] REG_UNMAPPED_LAST  = 8'hFF;

	localparam int NUM_SEGMENTS = 8;
	localparam int SEG_ITEMS    = 160;
	localparam int SETTLE_CYCLES = 6;
	localparam int REPORT_LIMIT = 10;

	typedef enum logic [1:0] {
		ROW_CFG,   // register write, pipeline drained first
		ROW_PRED,  // sample checked against the predictor
		ROW_HIT,   // sample with a point typed in
		ROW_MISS   // sample known to fall outside the window
	} row_kind_e;

	typedef enum logic [1:0] {
		IDLE_NONE,
		IDLE_SEND,
		IDLE_RECV,
		IDLE_BOTH
	} idle_mode_e;

	typedef struct packed {
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
	} point_t;

	typedef struct packed {
		row_kind_e                 kind;
		logic [CFG_INDEX_W-1:0]    idx;
		logic [CFG_DATA_W-1:0]     val;
		logic [RANGE_W-1:0]        rng;
		logic                      scan_first;
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
	} plan_row_t;

	localparam int PLAN_ROWS = 38;

	// Directed plan: reset state, quarter-turn steps, bogus indexes, window edges
	localparam plan_row_t PLAN [PLAN_ROWS] = '{
		'{ROW_HIT,  8'd0, 16'd0, 16'd0,     1'b0, 17'sd0,      17'sd0},
		'{ROW_HIT,  8'd0, 16'd0, 16'd65535, 1'b1, 17'sd65535,  17'sd0},
		'{ROW_HIT,  8'd0, 16'd0, 16'd1234,  1'b0, 17'sd1234,   17'sd0},
		'{ROW_CFG,  REG_ANGLE_STEP, 16'd16384, 16'd0, 1'b0, 17'sd0, 17'sd0},
		'{ROW_HIT,  8'd0, 16'd0, 16'd1000,  1'b1, 17'sd1000,   17'sd0},
		'{ROW_HIT,  8'd0, 16'd0, 16'd1000,  1'b0, 17'sd0,      17'sd1000},
		'{ROW_HIT,  8'd0, 16'd0, 16'd1000,  1'b0, -17'sd1000,  17'sd0},
		'{ROW_HIT,  8'd0, 16'd0, 16'd1000,  1'b0, 17'sd0,      -17'sd1000},
		'{ROW_HIT,  8'd0, 16'd0, 16'd65535, 1'b0, 17'sd65535,  17'sd0},
		'{ROW_HIT,  8'd0, 16'd0, 16'd65535, 1'b0, 17'sd0,      17'sd65535},
		'{ROW_HIT,  8'd0, 16'd0, 16'd65535, 1'b0, -17'sd65535, 17'sd0},
		'{ROW_HIT,  8'd0, 16'd0, 16'd65535, 1'b0, 17'sd0,      -17'sd65535},
		'{ROW_CFG,  REG_UNMAPPED_FIRST, 16'h00FF, 16'd0, 1'b0, 17'sd0, 17'sd0},
		'{ROW_CFG,  REG_UNMAPPED_LAST,  16'hFFFF, 16'd0, 1'b0, 17'sd0, 17'sd0},
		'{ROW_HIT,  8'd0, 16'd0, 16'd777,   1'b1, 17'sd777,    17'sd0},
		'{ROW_HIT,  8'd0, 16'd0, 16'd777,   1'b0, 17'sd0,      17'sd777},
		'{ROW_CFG,  REG_START_ANGLE, 16'hFFFF, 16'd0, 1'b0, 17'sd0, 17'sd0},
		'{ROW_CFG,  REG_ANGLE_STEP,  16'hFFFF, 16'd0, 1'b0, 17'sd0, 17'sd0},
		'{ROW_CFG,  REG_RANGE_LOW,   16'd100,  16'd0, 1'b0, 17'sd0, 17'sd0},
		'{ROW_CFG,  REG_RANGE_HIGH,  16'd200,  16'd0, 1'b0, 17'sd0, 17'sd0},
		'{ROW_MISS, 8'd0, 16'd0, 16'd99,    1'b1, 17'sd0, 17'sd0},
		'{ROW_PRED, 8'd0, 16'd0, 16'd100,   1'b0, 17'sd0, 17'sd0},
		'{ROW_PRED, 8'd0, 16'd0, 16'd200,   1'b0, 17'sd0, 17'sd0},
		'{ROW_MISS, 8'd0, 16'd0, 16'd201,   1'b0, 17'sd0, 17'sd0},
		'{ROW_MISS, 8'd0, 16'd0, 16'd65535, 1'b0, 17'sd0, 17'sd0},
		'{ROW_MISS, 8'd0, 16'd0, 16'd0,     1'b0, 17'sd0, 17'sd0},
		'{ROW_PRED, 8'd0, 16'd0, 16'd150,   1'b1, 17'sd0, 17'sd0},
		'{ROW_CFG,  REG_RANGE_LOW,   16'd500,  16'd0, 1'b0, 17'sd0, 17'sd0},
		'{ROW_CFG,  REG_RANGE_HIGH,  16'd400,  16'd0, 1'b0, 17'sd0, 17'sd0},
		'{ROW_MISS, 8'd0, 16'd0, 16'd450,   1'b1, 17'sd0, 17'sd0},
		'{ROW_MISS, 8'd0, 16'd0, 16'd500,   1'b0, 17'sd0, 17'sd0},
		'{ROW_MISS, 8'd0, 16'd0, 16'd400,   1'b0, 17'sd0, 17'sd0},
		'{ROW_CFG,  REG_START_ANGLE, 16'h1234, 16'd0, 1'b0, 17'sd0, 17'sd0},
		'{ROW_CFG,  REG_ANGLE_STEP,  16'h0ABC, 16'd0, 1'b0, 17'sd0, 17'sd0},
		'{ROW_CFG,  REG_RANGE_LOW,   16'd0,    16'd0, 1'b0, 17'sd0, 17'sd0},
		'{ROW_CFG,  REG_RANGE_HIGH,  16'hFFFF, 16'd0, 1'b0, 17'sd0, 17'sd0},
		'{ROW_PRED, 8'd0, 16'd0, 16'd40000, 1'b1, 17'sd0, 17'sd0},
		'{ROW_PRED, 8'd0, 16'd0, 16'h5555,  1'b0, 17'sd0, 17'sd0}
	};

	logic                   clk;
	logic                   arst_n;
	logic                   s_tvalid;
	logic                   s_tready;
	logic [15:0]            s_tdata;    // [15:0] range_mm
	logic                   s_tuser;    // [0] scan_start
	logic                   m_tvalid;
	logic                   m_tready;
	logic [39:0]            m_tdata;    // [16:0] x_mm, [33:17] y_mm, rest zero
	logic                   cfg_valid;
	logic                   cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;

	// Predictor copy of registers and beam angle
	logic [ANGLE_W-1:0]        shadow_start;
	logic [ANGLE_W-1:0]        shadow_step;
	logic [RANGE_W-1:0]        shadow_low;
	logic [RANGE_W-1:0]        shadow_high;
	logic [ANGLE_W-1:0]        beam_angle;
	logic signed [ENTRY_W-1:0] sine_lut [LUT_SIZE];

	point_t     pending_points[$];
	int unsigned send_gap_pct;
	int unsigned recv_stall_pct;
	int         mismatch_count;
	int         points_checked;
	int         samples_sent;
	int         samples_dropped;
	int         settings_used;

	lidar_polar_to_cartesian dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// Clock, 4 ns period
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Watchdog
	initial begin
		#4_000_000;
		$display("tb: watchdog expired with %0d points outstanding", pending_points.size());
		$display("tb: failure");
		$finish;
	end

	// Quarter-wave sine in Q15 from the odd Taylor series worked in Q30
	function automatic int quarter_wave(int unsigned j);
		longint unsigned phase;
		longint unsigned pw;
		longint          sum;
		longint          q;
		int unsigned     k;
		phase = (64'(j) * 64'd2 * PI_Q30 + (64'd1 << (LUT_BITS - 1))) >> LUT_BITS;
		pw = phase;
		sum = longint'(phase);
		for (k = 1; k <= 7; k++) begin
			pw = (pw * phase + (64'd1 << 29)) >> 30;
			pw = (pw * phase + (64'd1 << 29)) >> 30;
			pw = pw / 64'((2 * k) * (2 * k + 1));
			if (k % 2 == 1)
				sum = sum - longint'(pw);
			else
				sum = sum + longint'(pw);
		end
		if (sum < 0)
			sum = 0;
		q = (sum + 16384) / 32768;
		if (q > 32768)
			q = 32768;
		return int'(q);
	endfunction

	// range * Q15 entry, rounded half away from zero
	function automatic logic signed [COORD_W-1:0] scale_mm(logic [RANGE_W-1:0] rng,
			logic signed [ENTRY_W-1:0] entry);
		longint unsigned mag;
		longint unsigned prod;
		mag = (entry < 0) ? 64'(-int'(entry)) : 64'(int'(entry));
		prod = (64'(rng) * mag + 64'd16384) >> FRAC_BITS;
		return (entry < 0) ? COORD_W'(-prod) : COORD_W'(prod);
	endfunction

	// Advance the beam angle for one sample; returns 1 when it yields a point
	function automatic bit predict_point(logic [RANGE_W-1:0] rng, logic scan_first,
			output point_t pt);
		logic [LUT_BITS-1:0] idx;
		bit                  hit;
		if (scan_first)
			beam_angle = shadow_start;
		hit = (rng >= shadow_low) && (rng <= shadow_high);
		idx = beam_angle >> (ANGLE_W - LUT_BITS);
		pt.x = scale_mm(rng, sine_lut[LUT_BITS'(idx + LUT_QTR)]);
		pt.y = scale_mm(rng, sine_lut[idx]);
		beam_angle = beam_angle + shadow_step;
		return hit;
	endfunction

	function automatic void set_idle_mode(idle_mode_e mode);
		case (mode)
			IDLE_NONE: begin
				send_gap_pct = 0;
				recv_stall_pct = 0;
			end
			IDLE_SEND: begin
				send_gap_pct = 86;
				recv_stall_pct = 0;
			end
			IDLE_RECV: begin
				send_gap_pct = 0;
				recv_stall_pct = 86;
			end
			default: begin
				send_gap_pct = 25;
				recv_stall_pct = 25;
			end
		endcase
	endfunction

	function automatic void note_mismatch(string what, int want, int got);
		mismatch_count++;
		if (mismatch_count <= REPORT_LIMIT)
			$display("tb: mismatch on %s: expected %0d, got %0d", what, want, got);
	endfunction

	// Called at a falling edge; returns at the falling edge after acceptance
	task automatic send_sample(logic [RANGE_W-1:0] rng, logic scan_first, bit typed,
			bit typed_hit, point_t typed_pt);
		point_t pt;
		bit     hit;
		if ($urandom_range(0, 99) < send_gap_pct) begin
			s_tvalid <= 1'b0;
			do @(negedge clk); while ($urandom_range(0, 99) < send_gap_pct);
		end
		s_tvalid <= 1'b1;
		s_tdata <= rng;
		s_tuser <= scan_first;
		do @(posedge clk); while (!s_tready);
		hit = predict_point(rng, scan_first, pt);
		if (typed) begin
			hit = typed_hit;
			pt = typed_pt;
		end
		if (hit)
			pending_points.push_back(pt);
		else
			samples_dropped++;
		samples_sent++;
		@(negedge clk);
	endtask

	// Stop sending and let every point and any rejected sample leave the pipeline
	task automatic drain_pipeline();
		s_tvalid <= 1'b0;
		while (pending_points.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_START_ANGLE: shadow_start = val;
			REG_ANGLE_STEP:  shadow_step = val;
			REG_RANGE_LOW:   shadow_low = val;
			REG_RANGE_HIGH:  shadow_high = val;
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	// Receiver backpressure
	always @(negedge clk)
		m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);

	// Compare each accepted point against the oldest expectation
	always @(posedge clk) begin : check_points
		point_t want;
		point_t got;
		if (arst_n && m_tvalid && m_tready) begin
			got.x = m_tdata[16:0];
			got.y = m_tdata[33:17];
			if (pending_points.size() == 0) begin
				note_mismatch("unexpected point x", 0, int'(got.x));
			end else begin
				want = pending_points.pop_front();
				points_checked++;
				if (got.x !== want.x)
					note_mismatch("x_mm", int'(want.x), int'(got.x));
				if (got.y !== want.y)
					note_mismatch("y_mm", int'(want.y), int'(got.y));
			end
		end
	end

	initial begin : stimulus
		int                  quad;
		int                  j;
		int                  v;
		int unsigned         pick;
		logic [RANGE_W-1:0]  rng;
		logic [RANGE_W-1:0]  low;
		logic [RANGE_W-1:0]  high;
		logic                scan_first;
		point_t              typed_pt;
		plan_row_t           row;

		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = 1'b0;
		m_tready = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		mismatch_count = 0;
		points_checked = 0;
		samples_sent = 0;
		samples_dropped = 0;
		settings_used = 1;
		set_idle_mode(IDLE_NONE);

		shadow_start = '0;
		shadow_step = '0;
		shadow_low = '0;
		shadow_high = 16'hFFFF;
		beam_angle = '0;

		// Full-turn table from the quarter wave by symmetry
		for (int i = 0; i < LUT_SIZE; i++) begin
			quad = i / LUT_QTR;
			j = i % LUT_QTR;
			case (quad)
				0: v = quarter_wave(j);
				1: v = quarter_wave(LUT_QTR - j);
				2: v = -quarter_wave(j);
				default: v = -quarter_wave(LUT_QTR - j);
			endcase
			sine_lut[i] = ENTRY_W'(v);
		end

		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		repeat (2) @(negedge clk);

		// Directed plan
		for (int n = 0; n < PLAN_ROWS; n++) begin
			row = PLAN[n];
			typed_pt.x = row.x;
			typed_pt.y = row.y;
			case (row.kind)
				ROW_CFG: begin
					drain_pipeline();
					write_reg(row.idx, row.val);
					settings_used++;
				end
				ROW_PRED: send_sample(row.rng, row.scan_first, 1'b0, 1'b0, typed_pt);
				ROW_HIT:  send_sample(row.rng, row.scan_first, 1'b1, 1'b1, typed_pt);
				default:  send_sample(row.rng, row.scan_first, 1'b1, 1'b0, typed_pt);
			endcase
		end

		// Random scans, one register setting and idle mode per segment
		for (int seg = 0; seg < NUM_SEGMENTS; seg++) begin
			drain_pipeline();
			set_idle_mode(idle_mode_e'(seg % 4));
			if (seg == 0) begin
				low = '0;
				high = 16'hFFFF;
			end else begin
				low = $urandom_range(0, 30000);
				high = $urandom_range(low, 65535);
			end
			write_reg(REG_START_ANGLE, $urandom);
			write_reg(REG_ANGLE_STEP, (seg % 2 == 0) ? $urandom_range(1, 600) : $urandom);
			write_reg(REG_RANGE_LOW, low);
			write_reg(REG_RANGE_HIGH, high);
			settings_used++;
			for (int n = 0; n < SEG_ITEMS; n++) begin
				pick = $urandom_range(0, 9);
				if (pick < 4)
					rng = $urandom_range(0, 65535);
				else if (pick < 9)
					rng = $urandom_range(low, high);
				else
					case ($urandom_range(0, 3))
						0: rng = low - 1'b1;
						1: rng = low;
						2: rng = high;
						default: rng = high + 1'b1;
					endcase
				scan_first = (n == 0) || ($urandom_range(0, 15) == 0);
				send_sample(rng, scan_first, 1'b0, 1'b0, typed_pt);
			end
		end

		drain_pipeline();
		repeat (4 * SETTLE_CYCLES) @(negedge clk);

		$display("tb: %0d samples over %0d register settings, %0d outside the window",
			samples_sent, settings_used, samples_dropped);
		$display("tb: %0d points compared, %0d mismatches", points_checked, mismatch_count);
		if (mismatch_count == 0 && pending_points.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
